// ===== src/smacb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smacb_pkg
// Shared types and constants of the moving-average crossover backtest core.
// ----------------------------------------------------------------------------
package smacb_pkg;

    localparam int MAX_WINDOW_DEF = 256;
    localparam int PRICE_BITS_DEF = 32;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int PNL_W     = 40;
    localparam int DD_W      = 23;
    localparam int HQ_W      = 23;

    localparam logic [HQ_W-1:0] HUNDRED_Q = 23'd6553600;
    localparam longint PNL_MAX = 64'sd549755813887;
    localparam longint PNL_MIN = -64'sd549755813888;

    localparam logic [CFG_W-1:0] SLOW_RESET = 9'd20;
    localparam logic [CFG_W-1:0] FAST_RESET = 9'd10;

    localparam logic signed [1:0] POS_FLAT  = 2'sb00;
    localparam logic signed [1:0] POS_LONG  = 2'sb01;
    localparam logic signed [1:0] POS_SHORT = 2'sb11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOW_WINDOW = 1'b0,
        REG_FAST_WINDOW = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_CMP,
        ST_DMUL,
        ST_DSTART,
        ST_DWAIT,
        ST_BOOK,
        ST_PEAK,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

// ===== src/smacb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smacb_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module smacb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== src/smacb_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smacb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smacb_div
    import smacb_pkg::*;
#(
    parameter int NUM_W = 55,
    parameter int DEN_W = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [NUM_W-1:0]  i_dividend,
    input  wire [DEN_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_bit;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_bit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_bit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ===== src/sma_crossover_backtest.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sma_crossover_backtest
// Moving-average crossover strategy over a stream of candle closes.
// ----------------------------------------------------------------------------
// One candle at a time. The closes live in a ring RAM; both window sums are
// rebuilt on each candle by sweeping the most recent max(slow, fast) closes,
// one RAM read per cycle. A candle that closes a trade adds the serial profit
// division, one quotient bit per cycle. After reset or first_of_run no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module sma_crossover_backtest
    import smacb_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire [PRICE_BITS-1:0]   i_close_price,
    input  wire                    i_first_of_run,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic signed [1:0]      o_position,
    output logic signed [PNL_W-1:0] o_pnl_percent,
    output logic [DD_W-1:0]        o_drawdown_percent,
    output logic                   o_trade_closed,
    output logic                   o_averages_ready,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_W-1:0]        i_cfg_data
);
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = PRICE_BITS + WIN_W;
    localparam int MUL_W = SUM_W + WIN_W;
    localparam int NUM_W = PRICE_BITS + HQ_W;
    localparam int TW    = NUM_W + 2;
    localparam int DW    = PNL_W + 2;
    localparam logic signed [TW-1:0] T_MAX = TW'(PNL_MAX);
    localparam logic signed [TW-1:0] T_MIN = TW'(PNL_MIN);

    t_state r_state, n_state;

    logic [CFG_W-1:0]        r_slow_cfg, r_fast_cfg;
    logic [AW-1:0]           r_wp, r_rp;
    logic [WIN_W-1:0]        r_fill, r_sw, r_fw, r_cs, r_cf, r_k, r_rdk;
    logic                    r_rdv;
    logic [SUM_W-1:0]        r_slow_sum, r_fast_sum;
    logic [MUL_W-1:0]        r_fside, r_sside;
    logic [PRICE_BITS-1:0]   r_price, r_entry, r_num, r_den;
    logic [NUM_W-1:0]        r_dvd;
    logic signed [1:0]       r_pos;
    logic signed [PNL_W-1:0] r_total, r_peak;
    logic [DD_W-1:0]         r_dd;
    logic                    r_closed, r_avg_ready, r_div_start;

    logic                    w_accept;
    logic [PRICE_BITS-1:0]   w_price;
    logic [AW-1:0]           w_wp0;
    logic [WIN_W-1:0]        w_fill0, w_fill1, w_sw, w_fw, w_kmax;
    logic                    w_issue;
    logic [PRICE_BITS-1:0]   w_rd_data;
    logic                    w_div_done;
    logic [NUM_W-1:0]        w_quo;
    logic signed [TW-1:0]    w_t;
    logic signed [PNL_W-1:0] w_pk;
    logic signed [DW-1:0]    w_d, w_nd;
    logic                    w_gt, w_lt;

    function automatic logic [WIN_W-1:0] clamp_win(input logic [CFG_W-1:0] w);
        logic [WIN_W-1:0] v;
        v = WIN_W'(w);
        if (w == '0) begin
            v = WIN_W'(1);
        end else if (32'(w) > 32'(MAX_WINDOW)) begin
            v = WIN_W'(MAX_WINDOW);
        end
        return v;
    endfunction

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_price     = (i_close_price == '0) ? PRICE_BITS'(1) : i_close_price;
    assign w_wp0       = i_first_of_run ? '0 : r_wp;
    assign w_fill0     = i_first_of_run ? '0 : r_fill;
    assign w_fill1     = (w_fill0 == WIN_W'(MAX_WINDOW)) ? w_fill0 : w_fill0 + 1'b1;
    assign w_sw        = clamp_win(r_slow_cfg);
    assign w_fw        = clamp_win(r_fast_cfg);
    assign w_kmax      = (r_cs > r_cf) ? r_cs : r_cf;
    assign w_issue     = (r_state == ST_SUM) && (r_k < w_kmax);
    assign w_gt        = r_fside > r_sside;
    assign w_lt        = r_fside < r_sside;

    assign w_t = TW'(r_total) + $signed({2'b00, w_quo}) - $signed(TW'(HUNDRED_Q));
    assign w_pk = (r_total > r_peak) ? r_total : r_peak;
    assign w_d  = DW'(w_pk) - DW'(r_total);
    assign w_nd = (w_d > $signed(DW'(r_dd))) ? w_d : $signed(DW'(r_dd));

    smacb_ram #(
        .WIDTH (PRICE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (w_wp0),
        .i_wr_data (w_price),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_rp),
        .o_rd_data (w_rd_data)
    );

    smacb_div #(
        .NUM_W (NUM_W),
        .DEN_W (PRICE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SUM;
            end
            ST_SUM: begin
                if (!w_issue && !r_rdv) n_state = ST_MUL;
            end
            ST_MUL:  n_state = ST_CMP;
            ST_CMP: begin
                n_state = ST_FIN;
                if (r_avg_ready) begin
                    if (w_gt && r_pos == POS_SHORT) n_state = ST_DMUL;
                    if (w_lt && r_pos == POS_LONG)  n_state = ST_DMUL;
                end
            end
            ST_DMUL:   n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DWAIT;
            ST_DWAIT: begin
                if (w_div_done) n_state = ST_BOOK;
            end
            ST_BOOK:   n_state = ST_PEAK;
            ST_PEAK:   n_state = ST_FIN;
            ST_FIN: begin
                if (!o_valid || i_ready) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_cfg  <= SLOW_RESET;
            r_fast_cfg  <= FAST_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_pos       <= POS_FLAT;
            r_total     <= '0;
            r_peak      <= '0;
            r_dd        <= '0;
            r_entry     <= '0;
            r_rdv       <= 1'b0;
            r_div_start <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            r_div_start <= (r_state == ST_DMUL);
            r_rdv       <= w_issue;
            if (r_state == ST_FIN && (!o_valid || i_ready)) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SLOW_WINDOW: r_slow_cfg <= i_cfg_data;
                    REG_FAST_WINDOW: r_fast_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_wp   <= (w_wp0 == AW'(MAX_WINDOW - 1)) ? '0 : w_wp0 + 1'b1;
                        r_fill <= w_fill1;
                        if (i_first_of_run) begin
                            r_pos   <= POS_FLAT;
                            r_entry <= '0;
                            r_total <= '0;
                            r_peak  <= '0;
                            r_dd    <= '0;
                        end
                    end
                end
                ST_CMP: begin
                    if (r_avg_ready) begin
                        if (w_gt && r_pos != POS_LONG) begin
                            r_pos   <= POS_LONG;
                            r_entry <= r_price;
                        end else if (w_lt && r_pos != POS_SHORT) begin
                            r_pos   <= POS_SHORT;
                            r_entry <= r_price;
                        end
                    end
                end
                ST_BOOK: begin
                    if (w_t > T_MAX) begin
                        r_total <= PNL_W'(T_MAX);
                    end else if (w_t < T_MIN) begin
                        r_total <= PNL_W'(T_MIN);
                    end else begin
                        r_total <= PNL_W'(w_t);
                    end
                end
                ST_PEAK: begin
                    r_peak <= w_pk;
                    if (w_nd > $signed(DW'(HUNDRED_Q))) begin
                        r_dd <= HUNDRED_Q;
                    end else begin
                        r_dd <= DD_W'(w_nd);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_price    <= w_price;
                r_sw       <= w_sw;
                r_fw       <= w_fw;
                r_cs       <= (w_fill1 < w_sw) ? w_fill1 : w_sw;
                r_cf       <= (w_fill1 < w_fw) ? w_fill1 : w_fw;
                r_slow_sum <= SUM_W'(w_price);
                r_fast_sum <= SUM_W'(w_price);
                r_k        <= WIN_W'(1);
                r_rp       <= (w_wp0 == '0) ? AW'(MAX_WINDOW - 1) : w_wp0 - 1'b1;
                r_closed   <= 1'b0;
            end
            ST_SUM: begin
                r_rdk <= r_k;
                if (w_issue) begin
                    r_k  <= r_k + 1'b1;
                    r_rp <= (r_rp == '0) ? AW'(MAX_WINDOW - 1) : r_rp - 1'b1;
                end
                if (r_rdv) begin
                    if (r_rdk < r_cs) r_slow_sum <= r_slow_sum + SUM_W'(w_rd_data);
                    if (r_rdk < r_cf) r_fast_sum <= r_fast_sum + SUM_W'(w_rd_data);
                end
            end
            ST_MUL: begin
                r_fside     <= MUL_W'(r_fast_sum * r_sw);
                r_sside     <= MUL_W'(r_slow_sum * r_fw);
                r_avg_ready <= (r_fill >= r_sw);
            end
            ST_CMP: begin
                if (r_pos == POS_SHORT) begin
                    r_num <= r_entry;
                    r_den <= r_price;
                end else begin
                    r_num <= r_price;
                    r_den <= r_entry;
                end
                if (r_avg_ready) begin
                    if (w_gt && r_pos == POS_SHORT) r_closed <= 1'b1;
                    if (w_lt && r_pos == POS_LONG)  r_closed <= 1'b1;
                end
            end
            ST_DMUL: begin
                r_dvd <= NUM_W'(HUNDRED_Q * r_num);
            end
            ST_FIN: begin
                if (!o_valid || i_ready) begin
                    o_position         <= r_pos;
                    o_pnl_percent      <= r_total;
                    o_drawdown_percent <= r_dd;
                    o_trade_closed     <= r_closed;
                    o_averages_ready   <= r_avg_ready;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
